// ===== src/srsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsd_pkg
// Shared types and codes for the sprite run-length span decoder.
// ----------------------------------------------------------------------------
package srsd_pkg;

  localparam int OUT_COORD_W = 16;

  // Command byte codes
  localparam logic [7:0] CMD_EOL      = 8'h00;
  localparam logic [7:0] CMD_END      = 8'h80;
  localparam logic [7:0] CMD_SHADOW   = 8'hC0;
  localparam logic [7:0] CMD_CNT_FILL = 8'hC1;
  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [7:0] PAD_LEN      = 8'h80;

  typedef enum logic [1:0] {
    KIND_COLOR  = 2'd0,
    KIND_SHADOW = 2'd1,
    KIND_END    = 2'd2,
    KIND_RANGE  = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_LIT      = 6'b000010,
    MODE_SHD_SEL  = 6'b000100,
    MODE_SHD_CNT  = 6'b001000,
    MODE_FILL_CNT = 6'b010000,
    MODE_FILL_COL = 6'b100000
  } mode_t;

  typedef struct packed {
    kind_t                  kind;
    logic [OUT_COORD_W-1:0] col;
    logic [OUT_COORD_W-1:0] row;
    logic [7:0]             span_length;
    logic [7:0]             color_index;
    logic                   final_res;
  } res_t;

  // Results of one decode step; r0 is delivered first, then r1
  typedef struct packed {
    logic [1:0] n_res;
    res_t       r1;
    res_t       r0;
  } step_t;

endpackage
`default_nettype wire

// ===== src/srsd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsd_in_if
// Encoded byte channel: valid/ready with op, data_byte and last_byte.
// ----------------------------------------------------------------------------
interface srsd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output op, output data_byte, output last_byte,
                 input ready);
  modport sink(input valid, input op, input data_byte, input last_byte,
               output ready);
endinterface
`default_nettype wire

// ===== src/srsd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsd_out_if
// Span result channel: valid/ready with one span or end record.
// ----------------------------------------------------------------------------
interface srsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] col;
  logic [15:0] row;
  logic [7:0]  span_length;
  logic [7:0]  color_index;
  logic        final_res;

  modport source(output valid, output kind, output col, output row,
                 output span_length, output color_index, output final_res,
                 input ready);
  modport sink(input valid, input kind, input col, input row,
               input span_length, input color_index, input final_res,
               output ready);
endinterface
`default_nettype wire

// ===== src/sprite_rle_span_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_rle_span_decoder
// Decodes a sprite's run-length byte stream into pixel spans and end records.
// ----------------------------------------------------------------------------
// One byte transaction is taken per cycle while the result register has room.
// Each accepted byte sits in an input register, then a single pass of decode
// logic (mode select plus coordinate adders) updates the decoder state and
// writes all results of that byte into a two-entry result register, from which
// they leave one per cycle while the sink is ready. A byte causing two results
// (a span followed by an end record) holds the next byte in the input register
// while the result register drains, so while the sink is ready the rate is one
// byte per cycle for single-result bytes and one result per cycle otherwise;
// bytes with no result (commands, skips) pass at one per cycle.
// A new byte may load in the same cycle that the last waiting result leaves.
// ----------------------------------------------------------------------------
module sprite_rle_span_decoder #(
  parameter int COORD_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  srsd_in_if.sink         stream,
  srsd_out_if.source      spans
);

  // input register
  logic            in_valid;
  logic            in_op;
  logic [7:0]      in_byte;
  logic            in_last;

  logic            advance;
  logic            can_load;
  logic            head_valid;
  logic            pop;
  srsd_pkg::step_t step;
  srsd_pkg::res_t  head;

  assign advance      = in_valid && can_load;
  assign stream.ready = !in_valid || advance;
  assign pop          = head_valid && spans.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_op   <= stream.op;
      in_byte <= stream.data_byte;
      in_last <= stream.last_byte;
    end
  end

  srsd_decode #(
    .COORD_BITS(COORD_BITS)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .step_en   (advance),
    .op        (in_op),
    .data_byte (in_byte),
    .last_byte (in_last),
    .step      (step)
  );

  srsd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .ld         (step),
    .pop        (pop),
    .can_load   (can_load),
    .head_valid (head_valid),
    .head       (head)
  );

  assign spans.valid       = head_valid;
  assign spans.kind        = head.kind;
  assign spans.col         = head.col;
  assign spans.row         = head.row;
  assign spans.span_length = head.span_length;
  assign spans.color_index = head.color_index;
  assign spans.final_res   = head.final_res;

endmodule
`default_nettype wire

// ===== src/srsd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsd_decode
// Decoder state and single-pass step logic: one byte in, up to two results.
// ----------------------------------------------------------------------------
module srsd_decode #(
  parameter int COORD_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step_en,
  input  wire logic             op,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  output srsd_pkg::step_t       step
);

  srsd_pkg::mode_t       mode;
  logic [7:0]            cnt;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic                  finished;

  srsd_pkg::mode_t       mode_fed;
  logic [7:0]            cnt_fed;
  logic [7:0]            cnt_next;
  logic [COORD_BITS-1:0] col_cmd;
  logic [COORD_BITS-1:0] col_next;
  logic [COORD_BITS-1:0] row_next;
  logic                  span_v;
  logic                  span_emit;
  srsd_pkg::kind_t       span_kind;
  logic [7:0]            span_len;
  logic [7:0]            span_color;
  logic                  end_cmd;
  logic                  end_v;
  logic                  active;
  srsd_pkg::res_t        span_res;
  srsd_pkg::res_t        end_res;

  always_comb begin
    mode_fed   = mode;
    cnt_fed    = cnt;
    col_cmd    = col;
    row_next   = row;
    span_v     = 1'b0;
    span_kind  = srsd_pkg::KIND_COLOR;
    span_len   = 8'd0;
    span_color = 8'd0;
    end_cmd    = 1'b0;

    // first pass: the byte itself
    case (mode)
      srsd_pkg::MODE_LIT: begin
        span_v     = 1'b1;
        span_len   = 8'd1;
        span_color = data_byte;
        cnt_fed    = cnt - 8'd1;
        if (cnt == 8'd1) begin
          mode_fed = srsd_pkg::MODE_IDLE;
        end
      end
      srsd_pkg::MODE_SHD_SEL: begin
        if (data_byte[1:0] != 2'd0) begin
          span_v    = 1'b1;
          span_kind = srsd_pkg::KIND_SHADOW;
          span_len  = {6'd0, data_byte[1:0]};
          mode_fed  = srsd_pkg::MODE_IDLE;
        end else begin
          mode_fed  = srsd_pkg::MODE_SHD_CNT;
        end
      end
      srsd_pkg::MODE_SHD_CNT: begin
        span_v    = 1'b1;
        span_kind = srsd_pkg::KIND_SHADOW;
        span_len  = data_byte;
        mode_fed  = srsd_pkg::MODE_IDLE;
      end
      srsd_pkg::MODE_FILL_CNT: begin
        cnt_fed  = data_byte;
        mode_fed = srsd_pkg::MODE_FILL_COL;
      end
      srsd_pkg::MODE_FILL_COL: begin
        span_v     = 1'b1;
        span_len   = cnt;
        span_color = data_byte;
        cnt_fed    = 8'd0;
        mode_fed   = srsd_pkg::MODE_IDLE;
      end
      default: begin
        mode_fed = srsd_pkg::MODE_IDLE;
        if (data_byte == srsd_pkg::CMD_EOL) begin
          row_next = row + COORD_BITS'(1);
          col_cmd  = '0;
        end else if (data_byte < srsd_pkg::CMD_END) begin
          cnt_fed  = data_byte;
          mode_fed = srsd_pkg::MODE_LIT;
        end else if (data_byte == srsd_pkg::CMD_END) begin
          end_cmd  = 1'b1;
        end else if (data_byte < srsd_pkg::CMD_SHADOW) begin
          col_cmd  = col + COORD_BITS'(data_byte[5:0]);
        end else if (data_byte == srsd_pkg::CMD_SHADOW) begin
          mode_fed = srsd_pkg::MODE_SHD_SEL;
        end else if (data_byte == srsd_pkg::CMD_CNT_FILL) begin
          mode_fed = srsd_pkg::MODE_FILL_CNT;
        end else begin
          cnt_fed  = {2'd0, data_byte[5:0]};
          mode_fed = srsd_pkg::MODE_FILL_COL;
        end
      end
    endcase

    // padding pass on the last byte; a pad span never meets a first-pass span
    cnt_next = cnt_fed;
    if (!end_cmd && last_byte) begin
      case (mode_fed)
        srsd_pkg::MODE_SHD_SEL, srsd_pkg::MODE_SHD_CNT: begin
          span_v    = 1'b1;
          span_kind = srsd_pkg::KIND_SHADOW;
          span_len  = srsd_pkg::PAD_LEN;
        end
        srsd_pkg::MODE_FILL_CNT: begin
          span_v     = 1'b1;
          span_len   = srsd_pkg::PAD_LEN;
          span_color = srsd_pkg::PAD_BYTE;
          cnt_next   = 8'd0;
        end
        srsd_pkg::MODE_FILL_COL: begin
          span_v     = 1'b1;
          span_len   = cnt_fed;
          span_color = srsd_pkg::PAD_BYTE;
          cnt_next   = 8'd0;
        end
        srsd_pkg::MODE_LIT: begin
          cnt_next = 8'd0;
        end
        default: begin
          cnt_next = cnt_fed;
        end
      endcase
    end

    span_emit = span_v && (span_len != 8'd0);
    col_next  = span_emit ? col + COORD_BITS'(span_len) : col_cmd;
    end_v     = end_cmd || last_byte;
    active    = !op && !finished;

    span_res.kind        = span_kind;
    span_res.col         = srsd_pkg::OUT_COORD_W'(col);
    span_res.row         = srsd_pkg::OUT_COORD_W'(row);
    span_res.span_length = span_len;
    span_res.color_index = span_color;
    span_res.final_res   = !end_v;

    end_res.kind         = end_cmd ? srsd_pkg::KIND_END : srsd_pkg::KIND_RANGE;
    end_res.col          = srsd_pkg::OUT_COORD_W'(col_next);
    end_res.row          = srsd_pkg::OUT_COORD_W'(row_next);
    end_res.span_length  = 8'd0;
    end_res.color_index  = 8'd0;
    end_res.final_res    = 1'b1;

    step.r0    = span_emit ? span_res : end_res;
    step.r1    = end_res;
    step.n_res = active ? (2'(span_emit) + 2'(end_v)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= srsd_pkg::MODE_IDLE;
      cnt      <= 8'd0;
      col      <= '0;
      row      <= '0;
      finished <= 1'b0;
    end else if (step_en) begin
      if (op) begin
        mode     <= srsd_pkg::MODE_IDLE;
        cnt      <= 8'd0;
        col      <= '0;
        row      <= '0;
        finished <= 1'b0;
      end else if (!finished) begin
        mode     <= end_v ? srsd_pkg::MODE_IDLE : mode_fed;
        cnt      <= cnt_next;
        col      <= col_next;
        row      <= row_next;
        finished <= end_v;
      end
    end
  end

  // once ended, only a start op reopens the sprite
  a_fin_sticky: assert property (@(posedge clk) disable iff (rst)
    (finished && !(step_en && op)) |=> finished)
    else $error("finished dropped without start op");

  // a finished sprite yields nothing
  a_fin_quiet: assert property (@(posedge clk) disable iff (rst)
    (finished || op) |-> (step.n_res == 2'd0))
    else $error("result produced while finished or on start");

  // a byte that ends the sprite goes back to idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (step_en && !op && !finished && end_v) |=> (mode == srsd_pkg::MODE_IDLE))
    else $error("mode not idle after end");

endmodule
`default_nettype wire

// ===== src/srsd_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsd_out_buf
// Two-entry result register; loads a whole step's results, drains one a cycle while popped.
// ----------------------------------------------------------------------------
module srsd_out_buf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire srsd_pkg::step_t ld,
  input  wire logic            pop,
  output logic                 can_load,
  output logic                 head_valid,
  output srsd_pkg::res_t       head
);

  srsd_pkg::res_t res_q [2];
  logic [1:0]     cnt;

  assign head_valid = (cnt != 2'd0);
  assign head       = res_q[0];
  assign can_load   = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= ld.n_res;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q[0] <= ld.r0;
      res_q[1] <= ld.r1;
    end else if (pop) begin
      res_q[0] <= res_q[1];
    end
  end

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> ((cnt == 2'd0) || ((cnt == 2'd1) && pop)))
    else $error("load over undelivered results");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("result count overflow");

  // with two queued, the head is the span and the end follows
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> (!res_q[0].final_res && res_q[1].final_res))
    else $error("final flag out of order");

endmodule
`default_nettype wire
